>>> hw/rtl/p2a_pkg.sv
// Shared constants and tables for the pixel to ASCII downsampler.
package p2a_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W     = 8;
	localparam int CHAR_W    = 8;
	localparam int LUMA_W    = 18;
	localparam int PAL_N     = 10;
	localparam int PAL_IDX_W = 4;
	localparam int DIM_RESET = 30;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [9:0] W_RED   = 10'd299;
	localparam logic [9:0] W_GREEN = 10'd587;
	localparam logic [9:0] W_BLUE  = 10'd114;

	localparam logic [CHAR_W-1:0] NEWLINE = CHAR_W'(10);

	// weighted-sum thresholds: index k reached when sum >= 1000*ceil(255k/9)
	localparam logic [LUMA_W-1:0] LUMA_TH [PAL_N-1] = '{
		18'd29000, 18'd57000, 18'd85000, 18'd114000, 18'd142000,
		18'd170000, 18'd199000, 18'd227000, 18'd255000
	};

	// " .:-=+*#%@"
	localparam logic [CHAR_W-1:0] PALETTE [PAL_N] = '{
		8'd32, 8'd46, 8'd58, 8'd45, 8'd61, 8'd43, 8'd42, 8'd35, 8'd37, 8'd64
	};

endpackage

>>> hw/rtl/pixel_to_ascii_downsampler.sv
// Pixel to ASCII downsampler: raster RGB in, nearest-neighbour grid characters out.
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, red, green, blue       pixel in
//  out       out_valid/out_ready, char_code,           character out
//            last_of_run, frame_end
//  cfg       cfg_wr_en, cfg_index, cfg_data            register write
//
// One pixel a cycle while in_ready is high; sample selection and counters update
// at the input transfer. The pixel is registered, luma and palette index settle before
// the output register, which holds the characters for transfer.
// A sampled pixel holds the output register for 2 or 3 transfers; while it is busy and
// a second sampled pixel sits in the input register, in_ready drops.
// Reset clears counters and valids and sets each dimension to max(30, its grid size).
module pixel_to_ascii_downsampler
	import p2a_pkg::*;
#(
	parameter int GRID_COLS = 30,
	parameter int GRID_ROWS = 30,
	parameter int MAX_DIM   = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     red,
	input  logic [PIX_W-1:0]     green,
	input  logic [PIX_W-1:0]     blue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAR_W-1:0]    char_code,
	output logic                 last_of_run,
	output logic                 frame_end,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int GC_W  = $clog2(GRID_COLS + 1);
	localparam int GR_W  = $clog2(GRID_ROWS + 1);
	localparam int CP_W  = $clog2(GRID_COLS * MAX_DIM + 1);
	localparam int RP_W  = $clog2(GRID_ROWS * MAX_DIM + 1);
	localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int W_RST = (DIM_RESET < GRID_COLS) ? GRID_COLS : DIM_RESET;
	localparam int H_RST = (DIM_RESET < GRID_ROWS) ? GRID_ROWS : DIM_RESET;

	logic [DIM_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] scol_q, srow_q;
	logic [CP_W-1:0]  scol_scaled_q, col_prod_q;
	logic [RP_W-1:0]  srow_scaled_q, row_prod_q;
	logic [GC_W-1:0]  gcol_q;
	logic [GR_W-1:0]  grow_q;

	logic [CNT_W-1:0] scol_d, srow_d;
	logic [CP_W-1:0]  scol_scaled_d, col_prod_d;
	logic [RP_W-1:0]  srow_scaled_d, row_prod_d;
	logic [GC_W-1:0]  gcol_d;
	logic [GR_W-1:0]  grow_d;
	logic             row_sel, col_sel, hit, row_done, col_last, grid_last;

	logic             hit_s1, nl_s1, fe_s1;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;

	logic [1:0]        cnt_q;
	logic [CHAR_W-1:0] char_q;
	logic              nl_q, fe_q;

	logic              advance, in_xfer;
	logic [PAL_IDX_W-1:0] pal_idx;
	logic [LUMA_W-1:0] luma_d;

	logic [CMP_W-1:0] cfg_ext, w_clamp, h_clamp;

	// configuration with clamping
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext < CMP_W'(GRID_COLS))
			w_clamp = CMP_W'(GRID_COLS);
		else if (cfg_ext > CMP_W'(MAX_DIM))
			w_clamp = CMP_W'(MAX_DIM);
		else
			w_clamp = cfg_ext;
		if (cfg_ext < CMP_W'(GRID_ROWS))
			h_clamp = CMP_W'(GRID_ROWS);
		else if (cfg_ext > CMP_W'(MAX_DIM))
			h_clamp = CMP_W'(MAX_DIM);
		else
			h_clamp = cfg_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(W_RST);
			height_q <= DIM_W'(H_RST);
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_IMAGE_WIDTH)
				width_q <= w_clamp[DIM_W-1:0];
			else if (cfg_index == REG_IMAGE_HEIGHT)
				height_q <= h_clamp[DIM_W-1:0];
		end
	end

	// sample selection: floor(prod/GRID) == pos  <=>  pos*GRID <= prod < pos*GRID + GRID
	always_comb begin
		row_sel = (grow_q < GR_W'(GRID_ROWS)) && (row_prod_q >= srow_scaled_q) &&
			(row_prod_q < srow_scaled_q + RP_W'(GRID_ROWS));
		col_sel = (gcol_q < GC_W'(GRID_COLS)) && (col_prod_q >= scol_scaled_q) &&
			(col_prod_q < scol_scaled_q + CP_W'(GRID_COLS));
		hit       = row_sel && col_sel;
		col_last  = ((GC_W+1)'(gcol_q) + (GC_W+1)'(1)) >= (GC_W+1)'(GRID_COLS);
		grid_last = ((GR_W+1)'(grow_q) + (GR_W+1)'(1)) >= (GR_W+1)'(GRID_ROWS);
		row_done  = ((DIM_W+1)'(scol_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(width_q);

		scol_d        = scol_q;
		scol_scaled_d = scol_scaled_q;
		gcol_d        = gcol_q;
		col_prod_d    = col_prod_q;
		srow_d        = srow_q;
		srow_scaled_d = srow_scaled_q;
		grow_d        = grow_q;
		row_prod_d    = row_prod_q;

		if (hit) begin
			gcol_d     = gcol_q + GC_W'(1);
			col_prod_d = col_prod_q + CP_W'(width_q);
		end
		if (row_done) begin
			scol_d        = '0;
			scol_scaled_d = '0;
			gcol_d        = '0;
			col_prod_d    = '0;
			if (row_sel) begin
				grow_d     = grow_q + GR_W'(1);
				row_prod_d = row_prod_q + RP_W'(height_q);
			end
			if (((DIM_W+1)'(srow_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(height_q)) begin
				srow_d        = '0;
				srow_scaled_d = '0;
				grow_d        = '0;
				row_prod_d    = '0;
			end else begin
				srow_d        = srow_q + CNT_W'(1);
				srow_scaled_d = srow_scaled_q + RP_W'(GRID_ROWS);
			end
		end else begin
			scol_d        = scol_q + CNT_W'(1);
			scol_scaled_d = scol_scaled_q + CP_W'(GRID_COLS);
		end
	end

	assign advance  = !hit_s1 || (cnt_q == 2'd0);
	assign in_ready = advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q        <= '0;
			scol_scaled_q <= '0;
			gcol_q        <= '0;
			col_prod_q    <= '0;
			srow_q        <= '0;
			srow_scaled_q <= '0;
			grow_q        <= '0;
			row_prod_q    <= '0;
		end else if (in_xfer) begin
			scol_q        <= scol_d;
			scol_scaled_q <= scol_scaled_d;
			gcol_q        <= gcol_d;
			col_prod_q    <= col_prod_d;
			srow_q        <= srow_d;
			srow_scaled_q <= srow_scaled_d;
			grow_q        <= grow_d;
			row_prod_q    <= row_prod_d;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (advance) begin
			hit_s1 <= in_valid && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			nl_s1    <= col_last;
			fe_s1    <= grid_last;
		end
	end

	assign luma_d = LUMA_W'(W_RED) * LUMA_W'(red_s1) + LUMA_W'(W_GREEN) * LUMA_W'(green_s1) +
		LUMA_W'(W_BLUE) * LUMA_W'(blue_s1);

	always_comb begin
		pal_idx = '0;
		for (int k = 0; k < PAL_N - 1; k++)
			if (luma_d >= LUMA_TH[k])
				pal_idx = pal_idx + PAL_IDX_W'(1);
	end

	// output register: one sampled pixel, 2 or 3 transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance && hit_s1) begin
			cnt_q <= nl_s1 ? 2'd3 : 2'd2;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit_s1) begin
			char_q <= PALETTE[pal_idx];
			nl_q   <= nl_s1;
			fe_q   <= fe_s1;
		end
	end

	assign out_valid   = (cnt_q != 2'd0);
	assign last_of_run = (cnt_q == 2'd1);
	assign char_code   = (last_of_run && nl_q) ? NEWLINE : char_q;
	assign frame_end   = last_of_run && nl_q && fe_q;

endmodule

>>> tb/sv/pixel_to_ascii_downsampler_tb.sv
// Self-checking testbench for the pixel to ASCII downsampler.
`timescale 1ns / 1ps

module pixel_to_ascii_downsampler_tb
	import p2a_pkg::*;
();

	localparam int GRID_COLS     = 30;
	localparam int GRID_ROWS     = 30;
	localparam int MAX_DIM       = 4096;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	localparam logic [CHAR_W-1:0] GLYPHS [10] = '{
		" ", ".", ":", "-", "=", "+", "*", "#", "%", "@"
	};

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic              fend;
	} glyph_t;

	typedef struct packed {
		logic              fixed;
		logic [CHAR_W-1:0] code;
	} glyph_hint_t;

	typedef struct packed {
		logic [PIX_W-1:0]  r;
		logic [PIX_W-1:0]  g;
		logic [PIX_W-1:0]  b;
		logic              fixed;
		logic [CHAR_W-1:0] code;
	} pixel_row_t;

	// primaries and mixes typed in; grey steps straddle the first eight palette thresholds
	localparam pixel_row_t DIRECTED [24] = '{
		{8'd0,   8'd0,   8'd0,   1'b1, 8'h20},
		{8'd255, 8'd255, 8'd255, 1'b1, 8'h40},
		{8'd255, 8'd0,   8'd0,   1'b1, 8'h3a},
		{8'd0,   8'd255, 8'd0,   1'b1, 8'h2b},
		{8'd0,   8'd0,   8'd255, 1'b1, 8'h2e},
		{8'd255, 8'd255, 8'd0,   1'b1, 8'h23},
		{8'd0,   8'd255, 8'd255, 1'b1, 8'h2a},
		{8'd255, 8'd0,   8'd255, 1'b1, 8'h2d},
		{8'd28,  8'd28,  8'd28,  1'b0, 8'h00},
		{8'd29,  8'd29,  8'd29,  1'b0, 8'h00},
		{8'd56,  8'd56,  8'd56,  1'b0, 8'h00},
		{8'd57,  8'd57,  8'd57,  1'b0, 8'h00},
		{8'd84,  8'd84,  8'd84,  1'b0, 8'h00},
		{8'd85,  8'd85,  8'd85,  1'b0, 8'h00},
		{8'd113, 8'd113, 8'd113, 1'b0, 8'h00},
		{8'd114, 8'd114, 8'd114, 1'b0, 8'h00},
		{8'd141, 8'd141, 8'd141, 1'b0, 8'h00},
		{8'd142, 8'd142, 8'd142, 1'b0, 8'h00},
		{8'd169, 8'd169, 8'd169, 1'b0, 8'h00},
		{8'd170, 8'd170, 8'd170, 1'b0, 8'h00},
		{8'd198, 8'd198, 8'd198, 1'b0, 8'h00},
		{8'd199, 8'd199, 8'd199, 1'b0, 8'h00},
		{8'd226, 8'd226, 8'd226, 1'b0, 8'h00},
		{8'd227, 8'd227, 8'd227, 1'b0, 8'h00}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     red       = '0;
	logic [PIX_W-1:0]     green     = '0;
	logic [PIX_W-1:0]     blue      = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CHAR_W-1:0]    char_code;
	logic                 last_of_run;
	logic                 frame_end;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int unsigned img_w = 30;
	int unsigned img_h = 30;
	int unsigned pix_col = 0;
	int unsigned pix_row = 0;
	int unsigned cell_col = 0;
	int unsigned cell_row = 0;
	int unsigned col_acc = 0;
	int unsigned row_acc = 0;

	glyph_t      pending_glyphs [$];
	glyph_hint_t forced_glyphs [$];

	int          cycle_count = 0;
	int          mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	pixel_to_ascii_downsampler #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS),
		.MAX_DIM  (MAX_DIM)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.last_of_run(last_of_run),
		.frame_end  (frame_end),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("pixel_to_ascii_downsampler: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lo);
		if (v < lo)
			return lo;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] rand_level();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? '1 : '0;
		return PIX_W'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("cycle %0d: %s got %0d, expected %0d", cycle_count, field, got, want);
		mismatch_count++;
	endtask

	// nearest-neighbour sample selection and luma-to-glyph mapping for one pixel
	task automatic glyphs_for_pixel(input int unsigned r, input int unsigned g,
			input int unsigned b, input glyph_hint_t hint);
		int unsigned       luma;
		int unsigned       level;
		bit                row_hit;
		bit                col_hit;
		logic [CHAR_W-1:0] code;
		row_hit = (cell_row < GRID_ROWS) && (pix_row == row_acc / GRID_ROWS);
		col_hit = (cell_col < GRID_COLS) && (pix_col == col_acc / GRID_COLS);
		if (row_hit && col_hit) begin
			luma  = (299 * r + 587 * g + 114 * b) / 1000;
			level = luma * 9 / 255;
			code  = hint.fixed ? hint.code : GLYPHS[level];
			cell_col++;
			col_acc += img_w;
			pending_glyphs.push_back({code, 1'b0, 1'b0});
			if (cell_col >= GRID_COLS) begin
				pending_glyphs.push_back({code, 1'b0, 1'b0});
				pending_glyphs.push_back({NEWLINE, 1'b1, 1'(cell_row + 1 >= GRID_ROWS)});
			end else begin
				pending_glyphs.push_back({code, 1'b1, 1'b0});
			end
		end
		if (pix_col + 1 >= img_w) begin
			pix_col  = 0;
			cell_col = 0;
			col_acc  = 0;
			if (row_hit) begin
				cell_row++;
				row_acc += img_h;
			end
			if (pix_row + 1 >= img_h) begin
				pix_row  = 0;
				cell_row = 0;
				row_acc  = 0;
			end else begin
				pix_row++;
			end
		end else begin
			pix_col++;
		end
	endtask

	always @(posedge clk) begin
		glyph_hint_t hint;
		glyph_t      want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				hint = forced_glyphs.pop_front();
				glyphs_for_pixel(red, green, blue, hint);
			end
			if (out_valid && out_ready) begin
				if (pending_glyphs.size() == 0) begin
					report_mismatch("char_code with nothing pending", char_code, -1);
				end else begin
					want = pending_glyphs.pop_front();
					if (char_code !== want.code)
						report_mismatch("char_code", char_code, want.code);
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", last_of_run, want.last);
					if (frame_end !== want.fend)
						report_mismatch("frame_end", frame_end, want.fend);
				end
			end
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input glyph_hint_t hint);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		forced_glyphs.push_back(hint);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// leaves the write enable high so back-to-back writes need one assignment per edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  img_w = clamp_dim(data, GRID_COLS);
			REG_IMAGE_HEIGHT: img_h = clamp_dim(data, GRID_ROWS);
			default: ;
		endcase
	endtask

	task automatic settle();
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int unsigned n, input int unsigned send_pct, input int unsigned stall_pct);
		in_valid <= 1'b0;
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_wr_en      <= 1'b0;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		repeat (n)
			send_pixel(rand_level(), rand_level(), rand_level(), '0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// spare indexes must leave both dimensions alone
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '0);
		cfg_wr_en <= 1'b0;
		foreach (DIRECTED[i])
			send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b,
				{DIRECTED[i].fixed, DIRECTED[i].code});
		// one row taller than the grid
		run_phase(13'd30, 13'd31, 70, 0, 0);
		run_phase('1, '1, 70, 54, 0);
		run_phase('0, '0, 70, 0, 54);
		run_phase(CFG_W'($urandom_range(64, 30)), CFG_W'($urandom_range(64, 30)), 76, 12, 12);
		in_valid <= 1'b0;
		settle();
		#1;
		if (mismatch_count == 0)
			$display("pixel_to_ascii_downsampler: match");
		else
			$display("pixel_to_ascii_downsampler: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/p2a_pkg.sv
hw/rtl/pixel_to_ascii_downsampler.sv
tb/sv/pixel_to_ascii_downsampler_tb.sv
